/* rtl/core/sdf_pkg.sv */
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types, constants and the control store of the signed decimal
// formatter.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // Longest text emitted for one value
  localparam int MAX_FIELD  = 64;
  // Decimal digits of a 32-bit magnitude
  localparam int DIGIT_CNT  = 10;
  localparam int BCD_W      = 4 * DIGIT_CNT;
  // Shift-and-add-3 iterations, one per magnitude bit
  localparam int CONV_STEPS = 32;
  localparam int PC_W       = 4;

  // ASCII codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Microcode operations
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_CONV,
    OP_NORM,
    OP_FIXND,
    OP_BODY,
    OP_PAD,
    OP_EMIT,
    OP_EMPTY
  } op_t;

  // Character source of an emit step
  typedef enum logic [2:0] {
    SRC_LEAD,
    SRC_SIGN,
    SRC_ZERO,
    SRC_DIG,
    SRC_TRAIL
  } src_t;

  // One control word
  typedef struct packed {
    op_t             op;
    src_t            src;
    logic [PC_W-1:0] done_pc;
  } ctrl_t;

  // Step addresses
  localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
  localparam logic [PC_W-1:0] PC_CONV  = 4'd1;
  localparam logic [PC_W-1:0] PC_NORM  = 4'd2;
  localparam logic [PC_W-1:0] PC_FIXND = 4'd3;
  localparam logic [PC_W-1:0] PC_BODY  = 4'd4;
  localparam logic [PC_W-1:0] PC_PAD   = 4'd5;
  localparam logic [PC_W-1:0] PC_LEAD  = 4'd6;
  localparam logic [PC_W-1:0] PC_SIGN  = 4'd7;
  localparam logic [PC_W-1:0] PC_ZERO  = 4'd8;
  localparam logic [PC_W-1:0] PC_DIG   = 4'd9;
  localparam logic [PC_W-1:0] PC_TRAIL = 4'd10;
  localparam logic [PC_W-1:0] PC_EMPTY = 4'd11;

  // Control store: each step stays put until its condition holds, then jumps
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_WAIT, src: SRC_LEAD, done_pc: PC_WAIT};
    case (pc)
      PC_WAIT:  w = '{op: OP_WAIT,  src: SRC_LEAD,  done_pc: PC_CONV};
      PC_CONV:  w = '{op: OP_CONV,  src: SRC_LEAD,  done_pc: PC_NORM};
      PC_NORM:  w = '{op: OP_NORM,  src: SRC_LEAD,  done_pc: PC_FIXND};
      PC_FIXND: w = '{op: OP_FIXND, src: SRC_LEAD,  done_pc: PC_BODY};
      PC_BODY:  w = '{op: OP_BODY,  src: SRC_LEAD,  done_pc: PC_PAD};
      PC_PAD:   w = '{op: OP_PAD,   src: SRC_LEAD,  done_pc: PC_LEAD};
      PC_LEAD:  w = '{op: OP_EMIT,  src: SRC_LEAD,  done_pc: PC_SIGN};
      PC_SIGN:  w = '{op: OP_EMIT,  src: SRC_SIGN,  done_pc: PC_ZERO};
      PC_ZERO:  w = '{op: OP_EMIT,  src: SRC_ZERO,  done_pc: PC_DIG};
      PC_DIG:   w = '{op: OP_EMIT,  src: SRC_DIG,   done_pc: PC_TRAIL};
      PC_TRAIL: w = '{op: OP_EMIT,  src: SRC_TRAIL, done_pc: PC_EMPTY};
      PC_EMPTY: w = '{op: OP_EMPTY, src: SRC_LEAD,  done_pc: PC_WAIT};
      default:  w = '{op: OP_WAIT,  src: SRC_LEAD,  done_pc: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/signed_decimal_formatter.sv */
// ----------------------------------------------------------------------------
// signed_decimal_formatter
// Formats one signed 32-bit value as printf %d text, one character per item.
// ----------------------------------------------------------------------------
// Flow: after accepting a value the sequencer runs the 32 shift-and-add-3
//   steps, drops leading zero digits and skips empty runs, then emits the
//   text of up to 64 characters. The single microcode sequencer takes no
//   new value until the last character or the empty marker has been issued;
//   output stalls hold the sequencer in its current step.
// Reset: synchronous active-low rst_n returns the sequencer to its wait step
//   and drops out_valid; data registers are not reset.
module signed_decimal_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] in_value,
  input  logic [6:0]  in_min_width,
  input  logic [5:0]  in_min_digits,
  input  logic        in_has_precision,
  input  logic        in_force_plus,
  input  logic        in_space_sign,
  input  logic        in_left_justify,
  input  logic        in_zero_pad,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [7:0]  out_char,
  output logic        out_last,
  output logic        out_empty_res,
  output logic        out_valid,
  input  logic        out_ready
);

  // Sequencer
  logic [sdf_pkg::PC_W-1:0] pc_r, pc_nxt;
  sdf_pkg::ctrl_t           ctrl;
  logic                     step_done;

  // Captured item
  logic [5:0] prec_r, prec_nxt;
  logic       has_prec_r, has_prec_nxt;
  logic       plus_r, plus_nxt;
  logic       space_r, space_nxt;
  logic       left_r, left_nxt;
  logic       zpad_r, zpad_nxt;
  logic       neg_r, neg_nxt;
  logic [6:0] wsat_r, wsat_nxt;

  // Conversion
  logic [31:0]                bin_r, bin_nxt;
  logic [sdf_pkg::BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [sdf_pkg::BCD_W-1:0]  bcd_adj;
  logic [3:0]                 top_digit;
  logic [4:0]                 cnt_r, cnt_nxt;
  logic [3:0]                 nd_r, nd_nxt;

  // Layout
  logic [7:0] sign_c_r, sign_c_nxt;
  logic       sign_len_r, sign_len_nxt;
  logic [5:0] nz_r, nz_nxt;
  logic [6:0] body_r, body_nxt;
  logic [6:0] lead_r, lead_nxt;
  logic [6:0] zcnt_r, zcnt_nxt;
  logic [6:0] trail_r, trail_nxt;
  logic [6:0] tot_r, tot_nxt;
  logic [6:0] emit_cnt_r, emit_cnt_nxt;

  // Output register
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_empty_r, out_empty_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Helpers
  logic       can_push;
  logic [6:0] sel_cnt;
  logic [7:0] sel_char;
  logic [5:0] prec_eff;
  logic [5:0] nz_calc;
  logic [6:0] pad_calc;
  logic [6:0] tot_calc;
  logic       zmode;
  logic [31:0] mag;

  assign ctrl     = sdf_pkg::ucode(pc_r);
  assign can_push = !out_valid_r || out_ready;
  assign in_ready = (ctrl.op == sdf_pkg::OP_WAIT);

  assign out_char      = out_char_r;
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_r;
  assign out_valid     = out_valid_r;

  // Magnitude of the input, exact for the most negative value
  assign mag = in_value[31] ? (~in_value + 32'd1) : in_value;

  // Most significant BCD digit
  assign top_digit = bcd_r[sdf_pkg::BCD_W-1 -: 4];

  // Add 3 to every BCD digit of 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < sdf_pkg::DIGIT_CNT; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  // Layout arithmetic
  assign prec_eff = has_prec_r ? prec_r : 6'd0;
  assign nz_calc  = (prec_eff > {2'b00, nd_r}) ? (prec_eff - {2'b00, nd_r}) : 6'd0;
  assign pad_calc = (wsat_r > body_r) ? (wsat_r - body_r) : 7'd0;
  assign zmode    = zpad_r && !left_r && !has_prec_r;
  always_comb begin
    tot_calc = (wsat_r > body_r) ? wsat_r : body_r;
    if (tot_calc > 7'(sdf_pkg::MAX_FIELD)) begin
      tot_calc = 7'(sdf_pkg::MAX_FIELD);
    end
  end

  // Select the count and character of the current emit step
  always_comb begin
    case (ctrl.src)
      sdf_pkg::SRC_LEAD: begin
        sel_cnt  = lead_r;
        sel_char = sdf_pkg::CH_SPACE;
      end
      sdf_pkg::SRC_SIGN: begin
        sel_cnt  = {6'd0, sign_len_r};
        sel_char = sign_c_r;
      end
      sdf_pkg::SRC_ZERO: begin
        sel_cnt  = zcnt_r;
        sel_char = sdf_pkg::CH_ZERO;
      end
      sdf_pkg::SRC_DIG: begin
        sel_cnt  = {3'd0, nd_r};
        sel_char = sdf_pkg::CH_ZERO + {4'd0, top_digit};
      end
      sdf_pkg::SRC_TRAIL: begin
        sel_cnt  = trail_r;
        sel_char = sdf_pkg::CH_SPACE;
      end
      default: begin
        sel_cnt  = 7'd0;
        sel_char = sdf_pkg::CH_NUL;
      end
    endcase
  end

  // Step completion and next step address
  always_comb begin
    case (ctrl.op)
      sdf_pkg::OP_WAIT:  step_done = in_valid;
      sdf_pkg::OP_CONV:  step_done = (cnt_r == 5'(sdf_pkg::CONV_STEPS - 1));
      sdf_pkg::OP_NORM:  step_done = !((nd_r != 4'd0) && (top_digit == 4'd0));
      sdf_pkg::OP_EMIT:  step_done = (sel_cnt == 7'd0) || (emit_cnt_r == tot_r);
      sdf_pkg::OP_EMPTY: step_done = (tot_r != 7'd0) || can_push;
      default:           step_done = 1'b1;
    endcase
    pc_nxt = step_done ? ctrl.done_pc : pc_r;
  end

  // Datapath driven by the control word
  always_comb begin
    prec_nxt      = prec_r;
    has_prec_nxt  = has_prec_r;
    plus_nxt      = plus_r;
    space_nxt     = space_r;
    left_nxt      = left_r;
    zpad_nxt      = zpad_r;
    neg_nxt       = neg_r;
    wsat_nxt      = wsat_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    nd_nxt        = nd_r;
    sign_c_nxt    = sign_c_r;
    sign_len_nxt  = sign_len_r;
    nz_nxt        = nz_r;
    body_nxt      = body_r;
    lead_nxt      = lead_r;
    zcnt_nxt      = zcnt_r;
    trail_nxt     = trail_r;
    tot_nxt       = tot_r;
    emit_cnt_nxt  = emit_cnt_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (ctrl.op)
      // Capture the item and seed the converter
      sdf_pkg::OP_WAIT: begin
        if (in_valid) begin
          prec_nxt     = in_min_digits;
          has_prec_nxt = in_has_precision;
          plus_nxt     = in_force_plus;
          space_nxt    = in_space_sign;
          left_nxt     = in_left_justify;
          zpad_nxt     = in_zero_pad;
          neg_nxt      = in_value[31];
          wsat_nxt     = (in_min_width > 7'(sdf_pkg::MAX_FIELD)) ?
                         7'(sdf_pkg::MAX_FIELD) : in_min_width;
          bin_nxt      = mag;
          bcd_nxt      = '0;
          cnt_nxt      = 5'd0;
          nd_nxt       = 4'(sdf_pkg::DIGIT_CNT);
        end
      end
      // One binary bit into the BCD register
      sdf_pkg::OP_CONV: begin
        bcd_nxt = {bcd_adj[sdf_pkg::BCD_W-2:0], bin_r[31]};
        bin_nxt = {bin_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
      end
      // Drop leading zero digits
      sdf_pkg::OP_NORM: begin
        if ((nd_r != 4'd0) && (top_digit == 4'd0)) begin
          bcd_nxt = {bcd_r[sdf_pkg::BCD_W-5:0], 4'd0};
          nd_nxt  = nd_r - 4'd1;
        end
      end
      // Zero value prints one digit unless precision zero is given; pick the sign
      sdf_pkg::OP_FIXND: begin
        if ((nd_r == 4'd0) && !(has_prec_r && (prec_r == 6'd0))) begin
          nd_nxt = 4'd1;
        end
        if (neg_r) begin
          sign_c_nxt = sdf_pkg::CH_MINUS;
        end else if (plus_r) begin
          sign_c_nxt = sdf_pkg::CH_PLUS;
        end else begin
          sign_c_nxt = sdf_pkg::CH_SPACE;
        end
        sign_len_nxt = neg_r || plus_r || space_r;
      end
      // Precision zeros and body length
      sdf_pkg::OP_BODY: begin
        nz_nxt   = nz_calc;
        body_nxt = {6'd0, sign_len_r} + {1'b0, nz_calc} + {3'd0, nd_r};
      end
      // Place the padding and size the text
      sdf_pkg::OP_PAD: begin
        lead_nxt     = (!left_r && !zmode) ? pad_calc : 7'd0;
        zcnt_nxt     = {1'b0, nz_r} + (zmode ? pad_calc : 7'd0);
        trail_nxt    = left_r ? pad_calc : 7'd0;
        tot_nxt      = tot_calc;
        emit_cnt_nxt = 7'd0;
      end
      // Emit one character of the selected run
      sdf_pkg::OP_EMIT: begin
        if ((sel_cnt != 7'd0) && (emit_cnt_r != tot_r) && can_push) begin
          out_char_nxt  = sel_char;
          out_last_nxt  = ((emit_cnt_r + 7'd1) == tot_r);
          out_empty_nxt = 1'b0;
          out_valid_nxt = 1'b1;
          emit_cnt_nxt  = emit_cnt_r + 7'd1;
          case (ctrl.src)
            sdf_pkg::SRC_LEAD:  lead_nxt     = lead_r - 7'd1;
            sdf_pkg::SRC_SIGN:  sign_len_nxt = 1'b0;
            sdf_pkg::SRC_ZERO:  zcnt_nxt     = zcnt_r - 7'd1;
            sdf_pkg::SRC_DIG: begin
              nd_nxt  = nd_r - 4'd1;
              bcd_nxt = {bcd_r[sdf_pkg::BCD_W-5:0], 4'd0};
            end
            sdf_pkg::SRC_TRAIL: trail_nxt    = trail_r - 7'd1;
            default: ;
          endcase
        end
      end
      // Empty text gives one marker item
      sdf_pkg::OP_EMPTY: begin
        if ((tot_r == 7'd0) && can_push) begin
          out_char_nxt  = sdf_pkg::CH_NUL;
          out_last_nxt  = 1'b1;
          out_empty_nxt = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= sdf_pkg::PC_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Data registers
  always_ff @(posedge clk) begin
    prec_r      <= prec_nxt;
    has_prec_r  <= has_prec_nxt;
    plus_r      <= plus_nxt;
    space_r     <= space_nxt;
    left_r      <= left_nxt;
    zpad_r      <= zpad_nxt;
    neg_r       <= neg_nxt;
    wsat_r      <= wsat_nxt;
    bin_r       <= bin_nxt;
    bcd_r       <= bcd_nxt;
    cnt_r       <= cnt_nxt;
    nd_r        <= nd_nxt;
    sign_c_r    <= sign_c_nxt;
    sign_len_r  <= sign_len_nxt;
    nz_r        <= nz_nxt;
    body_r      <= body_nxt;
    lead_r      <= lead_nxt;
    zcnt_r      <= zcnt_nxt;
    trail_r     <= trail_nxt;
    tot_r       <= tot_nxt;
    emit_cnt_r  <= emit_cnt_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

endmodule

/* rtl/core/sdf_checker.sv */
// ----------------------------------------------------------------------------
// sdf_checker
// Port-level checks of the signed decimal formatter, bound to the top level.
// ----------------------------------------------------------------------------
module sdf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  out_char,
  input logic        out_last,
  input logic        out_empty_res,
  input logic        out_valid,
  input logic        out_ready
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled result item changed");

  // Empty marker is a lone NUL that closes the text
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last && (out_char == 8'h00))
    else $error("malformed empty item");

  // Real characters are never NUL
  a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_res |-> (out_char != 8'h00))
    else $error("NUL character in text");

  // Conversion follows every accepted item, so input stays closed next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened right after accept");

endmodule

bind signed_decimal_formatter sdf_checker u_sdf_checker (.*);

/* tb/sv/signed_decimal_formatter_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_formatter_checker
// Watches both channels of the formatter. Each accepted value is turned into
// its expected printf %d text, and each emitted character is compared in
// order against that text.
// ----------------------------------------------------------------------------
module signed_decimal_formatter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] in_value,
  input  logic [6:0]  in_min_width,
  input  logic [5:0]  in_min_digits,
  input  logic        in_has_precision,
  input  logic        in_force_plus,
  input  logic        in_space_sign,
  input  logic        in_left_justify,
  input  logic        in_zero_pad,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  out_char,
  input  logic        out_last,
  input  logic        out_empty_res,
  input  logic        out_valid,
  input  logic        out_ready,
  output int          fail_count,
  output int          pending_chars
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty;
  } text_char_t;

  // Characters still owed by the block, oldest first
  text_char_t expected_text[$];
  int         mismatches = 0;

  assign fail_count = mismatches;

  // Build the formatted text of one value and queue its characters
  function automatic void format_value(input logic [31:0] value,
                                       input logic [6:0]  width_in,
                                       input logic [5:0]  digits_in,
                                       input logic        has_prec,
                                       input logic        plus,
                                       input logic        space,
                                       input logic        left,
                                       input logic        zpad);
    logic [31:0] mag;
    logic [31:0] rem;
    logic [7:0]  sign_ch;
    logic [7:0]  digits[$];
    logic [7:0]  text[$];
    int          prec;
    int          nz;
    int          body;
    int          width;
    int          pad;
    int          n;
    int          i;
    mag = value[31] ? (32'd0 - value) : value;
    while (mag != 32'd0) begin
      rem = mag % 32'd10;
      digits.push_front(sdf_pkg::CH_ZERO + rem[7:0]);
      mag = mag / 32'd10;
    end
    prec = has_prec ? int'(digits_in) : 0;
    // zero prints one digit unless an explicit precision of zero is given
    if (digits.size() == 0 && !(has_prec && prec == 0)) digits.push_back(sdf_pkg::CH_ZERO);

    if (value[31]) sign_ch = sdf_pkg::CH_MINUS;
    else if (plus) sign_ch = sdf_pkg::CH_PLUS;
    else if (space) sign_ch = sdf_pkg::CH_SPACE;
    else sign_ch = sdf_pkg::CH_NUL;

    nz    = prec > digits.size() ? prec - digits.size() : 0;
    body  = int'(sign_ch != sdf_pkg::CH_NUL) + nz + digits.size();
    width = int'(width_in) > sdf_pkg::MAX_FIELD ? sdf_pkg::MAX_FIELD : int'(width_in);
    pad   = width > body ? width - body : 0;

    // padding goes before the sign, after the sign or after the digits
    if (!left && !(zpad && !has_prec)) repeat (pad) text.push_back(sdf_pkg::CH_SPACE);
    if (sign_ch != sdf_pkg::CH_NUL) text.push_back(sign_ch);
    if (!left && zpad && !has_prec) repeat (pad) text.push_back(sdf_pkg::CH_ZERO);
    repeat (nz) text.push_back(sdf_pkg::CH_ZERO);
    foreach (digits[d]) text.push_back(digits[d]);
    if (left) repeat (pad) text.push_back(sdf_pkg::CH_SPACE);

    // truncate to the field limit, mark the final character
    n = text.size() > sdf_pkg::MAX_FIELD ? sdf_pkg::MAX_FIELD : text.size();
    if (n == 0) expected_text.push_back('{ch: sdf_pkg::CH_NUL, last: 1'b1, empty: 1'b1});
    for (i = 0; i < n; i++)
      expected_text.push_back('{ch: text[i], last: (i == n - 1), empty: 1'b0});
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Compare emitted characters first, then queue the text of a new value
  always @(posedge clk) begin : monitor
    text_char_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch("char with nothing expected", out_char, sdf_pkg::CH_NUL);
        end else begin
          want = expected_text.pop_front();
          if (out_char !== want.ch) report_mismatch("out_char", out_char, want.ch);
          if (out_last !== want.last)
            report_mismatch("out_last", {7'd0, out_last}, {7'd0, want.last});
          if (out_empty_res !== want.empty)
            report_mismatch("out_empty_res", {7'd0, out_empty_res}, {7'd0, want.empty});
        end
      end
      if (in_valid && in_ready)
        format_value(in_value, in_min_width, in_min_digits, in_has_precision,
                     in_force_plus, in_space_sign, in_left_justify, in_zero_pad);
    end
    pending_chars <= expected_text.size();
  end

endmodule

/* tb/sv/signed_decimal_formatter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_formatter_tb
// Drives the formatter with directed corner values and random %d requests
// under random idling on both sides, including one long output stall, and
// gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module signed_decimal_formatter_tb;

  localparam int RANDOM_ITEMS = 350;
  localparam int QUIET_TAIL   = 40;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 100;

  // Flag bits of one request
  localparam logic [4:0] FL_NONE  = 5'b00000;
  localparam logic [4:0] FL_PREC  = 5'b10000;
  localparam logic [4:0] FL_PLUS  = 5'b01000;
  localparam logic [4:0] FL_SPACE = 5'b00100;
  localparam logic [4:0] FL_LEFT  = 5'b00010;
  localparam logic [4:0] FL_ZERO  = 5'b00001;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [31:0] in_value = '0;
  logic [6:0]  in_min_width = '0;
  logic [5:0]  in_min_digits = '0;
  logic        in_has_precision = 1'b0;
  logic        in_force_plus = 1'b0;
  logic        in_space_sign = 1'b0;
  logic        in_left_justify = 1'b0;
  logic        in_zero_pad = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  out_char;
  logic        out_last;
  logic        out_empty_res;
  logic        out_valid;
  logic        out_ready = 1'b0;

  int   fail_count;
  int   pending_chars;
  int   gap_pct = 0;
  logic long_hold_req = 1'b0;
  logic quiet = 1'b0;

  always #2 clk = ~clk;

  signed_decimal_formatter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_value         (in_value),
    .in_min_width     (in_min_width),
    .in_min_digits    (in_min_digits),
    .in_has_precision (in_has_precision),
    .in_force_plus    (in_force_plus),
    .in_space_sign    (in_space_sign),
    .in_left_justify  (in_left_justify),
    .in_zero_pad      (in_zero_pad),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_char         (out_char),
    .out_last         (out_last),
    .out_empty_res    (out_empty_res),
    .out_valid        (out_valid),
    .out_ready        (out_ready)
  );

  signed_decimal_formatter_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_value         (in_value),
    .in_min_width     (in_min_width),
    .in_min_digits    (in_min_digits),
    .in_has_precision (in_has_precision),
    .in_force_plus    (in_force_plus),
    .in_space_sign    (in_space_sign),
    .in_left_justify  (in_left_justify),
    .in_zero_pad      (in_zero_pad),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_char         (out_char),
    .out_last         (out_last),
    .out_empty_res    (out_empty_res),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .fail_count       (fail_count),
    .pending_chars    (pending_chars)
  );

  // Offer one item, hold it until accepted, then maybe idle for a burst
  task automatic send_value(input logic [31:0] v, input logic [6:0] w,
                            input logic [5:0] p, input logic [4:0] fl);
    int gap;
    in_value         <= v;
    in_min_width     <= w;
    in_min_digits    <= p;
    in_has_precision <= (fl & FL_PREC) != 0;
    in_force_plus    <= (fl & FL_PLUS) != 0;
    in_space_sign    <= (fl & FL_SPACE) != 0;
    in_left_justify  <= (fl & FL_LEFT) != 0;
    in_zero_pad      <= (fl & FL_ZERO) != 0;
    in_valid         <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!quiet && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off, none in the tail
  initial begin : receiver
    int   stall_left;
    int   stall_pct;
    int   regime_left;
    logic hold_done;
    stall_left  = 0;
    stall_pct   = 0;
    regime_left = 0;
    hold_done   = 1'b0;
    forever begin
      @(posedge clk);
      if (regime_left == 0) begin
        regime_left = $urandom_range(32, 96);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 5;
          default: stall_pct = 30;
        endcase
      end
      regime_left--;
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(1, 100) <= stall_pct) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic [31:0] v;
    logic [31:0] pw;
    logic [6:0]  w;
    logic [5:0]  p;
    logic [4:0]  fl;
    int          i;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: zero, extremes, each flag, overrides, saturation
    send_value(32'd0,          7'd0,   6'd0,  FL_NONE);
    send_value(32'd0,          7'd0,   6'd0,  FL_PREC);
    send_value(32'd0,          7'd5,   6'd0,  FL_PREC);
    send_value(32'd0,          7'd0,   6'd0,  FL_PREC | FL_PLUS);
    send_value(32'd0,          7'd3,   6'd0,  FL_PREC | FL_SPACE | FL_LEFT);
    send_value(32'h8000_0000,  7'd0,   6'd0,  FL_NONE);
    send_value(32'h7FFF_FFFF,  7'd0,   6'd0,  FL_PLUS);
    send_value(32'hFFFF_FFFF,  7'd8,   6'd0,  FL_ZERO);
    send_value(32'd42,         7'd0,   6'd0,  FL_SPACE);
    send_value(32'd42,         7'd6,   6'd0,  FL_PLUS | FL_SPACE);
    send_value(32'd42,         7'd10,  6'd0,  FL_PLUS | FL_LEFT);
    send_value(32'd42,         7'd10,  6'd0,  FL_LEFT | FL_ZERO);
    send_value(32'd42,         7'd10,  6'd5,  FL_PREC | FL_ZERO);
    send_value(-32'sd12,       7'd10,  6'd5,  FL_PREC | FL_ZERO);
    send_value(32'd123,        7'd127, 6'd0,  FL_NONE);
    send_value(-32'sd5,        7'd64,  6'd0,  FL_ZERO);
    send_value(32'h8000_0000,  7'd127, 6'd63, FL_PREC | FL_LEFT);
    send_value(32'd7,          7'd0,   6'd63, FL_NONE);
    send_value(32'd7,          7'd0,   6'd63, FL_PREC | FL_PLUS);
    send_value(32'd1000000000, 7'd11,  6'd0,  FL_NONE);
    send_value(32'h8000_0000,  7'd64,  6'd0,  FL_ZERO | FL_SPACE);
    send_value(32'd99,         7'd2,   6'd2,  FL_PREC);
    send_value(32'd1,          7'd65,  6'd0,  FL_PLUS | FL_ZERO);

    // Random requests, mostly short fields with occasional wide ones
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 40;
        endcase
      end
      if (i == 60) long_hold_req <= 1'b1;
      if (i == RANDOM_ITEMS - QUIET_TAIL) quiet <= 1'b1;

      case ($urandom_range(0, 5))
        0: v = $urandom;
        1: v = $urandom_range(0, 99);
        2: v = 32'd0 - $urandom_range(0, 99);
        3: begin
          case ($urandom_range(0, 4))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'hFFFF_FFFF;
            3: v = 32'd0;
            default: v = 32'h8000_0001;
          endcase
        end
        4: begin
          pw = 32'd1;
          repeat ($urandom_range(0, 9)) pw = pw * 32'd10;
          case ($urandom_range(0, 3))
            0: v = pw;
            1: v = pw - 32'd1;
            2: v = 32'd0 - pw;
            default: v = 32'd1 - pw;
          endcase
        end
        default: v = $urandom >> $urandom_range(0, 31);
      endcase
      w  = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                          : $urandom_range(0, 20));
      p  = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                          : $urandom_range(0, 12));
      fl = 5'($urandom_range(0, 31));
      send_value(v, w, p, fl);
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed character, then let the block settle
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("signed_decimal_formatter_tb: PASS");
    end else begin
      $display("signed_decimal_formatter_tb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #8_000_000;
    $display("signed_decimal_formatter_tb: FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/sdf_pkg.sv
rtl/core/signed_decimal_formatter.sv
rtl/core/sdf_checker.sv
tb/sv/signed_decimal_formatter_checker.sv
tb/sv/signed_decimal_formatter_tb.sv
